// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the stamp block. Each use sits on its own line.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define RFGS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high
`define RFGS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rfgs_pkg.sv =====
// ----------------------------------------------------------------------------
// rfgs_pkg
// Shared types and constants of the radial falloff grid stamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfgs_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_IGNITE = 2'd0;
  localparam logic [1:0] FUNC_SEED   = 2'd1;
  localparam logic [1:0] FUNC_RESET  = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Z = 2'd1;
  localparam logic [1:0] CFG_EXTENT_X = 2'd2;
  localparam logic [1:0] CFG_EXTENT_Z = 2'd3;

  // Field widths
  localparam int POS_W  = 24;
  localparam int AMT_W  = 16;
  localparam int CELL_W = 9;
  localparam int CHG_W  = 19;
  localparam int VAL_W  = 16;
  localparam int FCT_W  = AMT_W + 3;   // amount * 8

  // Value limits
  localparam logic [VAL_W-1:0] Q15_ONE  = 16'h8000;
  localparam logic [VAL_W-1:0] TEMP_MAX = 16'hFFFF;
  localparam logic [CHG_W-1:0] CHG_MAX  = 19'h7FFFF;
  localparam logic [POS_W-1:0] EXT_RST  = 24'h010000;

  // One grid cell as held in the store
  typedef struct packed {
    logic [VAL_W-1:0] temp;
    logic [VAL_W-1:0] fire;
    logic [VAL_W-1:0] fuel;
  } cell_t;

endpackage

`default_nettype wire

// ===== src/rfgs_mem.sv =====
// ----------------------------------------------------------------------------
// rfgs_mem
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfgs_mem
  import rfgs_pkg::*;
#(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire cell_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output cell_t              rdata
);

  cell_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rfgs_div.sv =====
// ----------------------------------------------------------------------------
// rfgs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfgs_div #(
  parameter int NW  = 38,
  parameter int DVW = 42
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DVW-1:0] den,
  output logic                done,
  output logic [NW-1:0]       quo,
  output logic                rem_nz
);

  localparam int CNTW = $clog2(NW);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   numsh;
  logic [DVW-1:0]  rem;
  logic [DVW-1:0]  dvs;
  logic [DVW:0]    trial;
  logic [DVW:0]    diff;
  logic            ge;

  // One trial subtract per cycle
  always_comb begin
    trial = {rem, numsh[NW-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= '0;
        numsh <= num;
        dvs   <= den;
        rem   <= '0;
        quo   <= '0;
      end else if (run) begin
        rem   <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
        quo   <= {quo[NW-2:0], ge};
        numsh <= {numsh[NW-2:0], 1'b0};
        cnt   <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_nz = (rem != '0);

endmodule

`default_nettype wire

// ===== src/rfgs_isqrt.sv =====
// ----------------------------------------------------------------------------
// rfgs_isqrt
// Integer square root, digit by digit, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfgs_isqrt #(
  parameter int VW = 38   // even
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [VW-1:0]   val,
  output logic                 done,
  output logic [VW/2-1:0]      root
);

  logic          run;
  logic [VW-1:0] v;
  logic [VW-1:0] res;
  logic [VW-1:0] bitm;
  logic [VW-1:0] sum;

  assign sum = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        v    <= val;
        res  <= '0;
        bitm <= {2'b01, {(VW-2){1'b0}}};
      end else if (run) begin
        if (v >= sum) begin
          v   <= v - sum;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[VW/2-1:0];

endmodule

`default_nettype wire

// ===== src/radial_falloff_grid_stamp.sv =====
// ----------------------------------------------------------------------------
// radial_falloff_grid_stamp
// Circular brush with linear falloff over a GRID_SIZE x GRID_SIZE cell store.
// Request channel (req_valid/req_stall) carries one word: func, position,
// radius, amount and read coordinates. Response channel (rsp_valid/rsp_stall)
// returns one word per request: status, cells_changed and the read cell.
// One request is in work at a time; req_stall is high while it runs.
// Stamp: three setup divisions on the shared divider, then for each cell of
// the clipped bounding square a distance step and a circle test, plus for
// each cell inside the circle a square root, a falloff division and a
// write.
// Reset map: one cell per cycle. Read: one store read for a cell in the grid.
// After rst the store is swept to full fuel with req_stall high;
// configuration writes are taken at any time.
// A finished word waits in the response register while rsp_stall is high;
// the next request is accepted as soon as the current one is handed over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module radial_falloff_grid_stamp
  import rfgs_pkg::*;
#(
  parameter int GRID_SIZE = 512
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [POS_W-1:0]  cfg_data,
  // request
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [1:0]        func,
  input  wire logic [POS_W-1:0]  pos_x,
  input  wire logic [POS_W-1:0]  pos_z,
  input  wire logic [POS_W-1:0]  radius,
  input  wire logic [AMT_W-1:0]  amount,
  input  wire logic [CELL_W-1:0] cell_x,
  input  wire logic [CELL_W-1:0] cell_y,
  // response
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic                   status,
  output logic [CHG_W-1:0]       cells_changed,
  output logic [VAL_W-1:0]       fuel_out,
  output logic [VAL_W-1:0]       fire_out,
  output logic [VAL_W-1:0]       temp_out
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int DW    = $clog2(GRID_SIZE + 1);
  localparam int RCW   = DW + 1;
  localparam int RC2W  = 2 * RCW;
  localparam int SW    = 2 * DW + 1;
  localparam int VW    = 2 * DW + 18;
  localparam int QW    = VW / 2;
  localparam int RW    = POS_W + DW;
  localparam int NUM_W = 28 + DW;
  localparam int DEN_W = 32 + DW;
  localparam int BW    = DW + 3;
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam logic [RCW-1:0]   RCMAX   = {RCW{1'b1}};
  localparam logic [CHG_W-1:0] CLR_CHG =
    (CELLS > 524287) ? CHG_MAX : CHG_W'(CELLS);

  // State codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_DIVX = 4'd3;
  localparam logic [3:0] ST_DIVZ = 4'd4;
  localparam logic [3:0] ST_DIVR = 4'd5;
  localparam logic [3:0] ST_SETP = 4'd6;
  localparam logic [3:0] ST_CELL = 4'd7;
  localparam logic [3:0] ST_CIRC = 4'd8;
  localparam logic [3:0] ST_SQRT = 4'd9;
  localparam logic [3:0] ST_DIVF = 4'd10;
  localparam logic [3:0] ST_WR   = 4'd11;
  localparam logic [3:0] ST_RD   = 4'd12;
  localparam logic [3:0] ST_RDW  = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  logic [3:0] state;

  // Configuration registers
  logic [POS_W-1:0] center_x, center_z, extent_x, extent_z;

  // Latched request
  logic [1:0]        func_r;
  logic [POS_W-1:0]  posx, posz, rad;
  logic [AMT_W-1:0]  amt;
  logic [CELL_W-1:0] cxr, cyr;

  // Stamp working registers
  logic [DW-1:0]    cx, cy;
  logic [RW-1:0]    rrad;
  logic [RC2W-1:0]  rc2;
  logic [CW-1:0]    xlo, xhi, ylo, yhi, px, py;
  logic [SW-1:0]    s;
  logic [FCT_W-1:0] fct;
  logic [CHG_W-1:0] cnt;
  logic [AW-1:0]    clr_addr;
  logic [VAL_W-1:0] clr_fuel;
  logic             clr_req;

  // Staged result
  logic             res_status;
  logic [CHG_W-1:0] res_count;
  cell_t            res_cell;

  // Shared divider and square root
  logic             div_start, div_done, div_rem_nz;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             sq_start, sq_done;
  logic [VW-1:0]    sq_val;
  logic [QW-1:0]    sq_root;

  // Memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr, cell_addr, rd_addr;
  cell_t         mem_wdata, mem_rdata;

  // Combinational helpers
  logic [POS_W-1:0]       exx, exz;
  logic signed [24:0]     dxw, dzw;
  logic signed [26:0]     d2x, d2z, exsx, exsz, nxs, nzs;
  logic                   reject;
  logic [RCW-1:0]         rc;
  logic signed [BW-1:0]   lox, hix, loy, hiy;
  logic signed [DW:0]     dxs, dys;
  logic [DW-1:0]          adx, ady;
  logic                   in_circ, last, rd_in;
  logic [FCT_W-1:0]       amt8;
  logic [CHG_W-1:0]       cnt_inc;
  logic [FCT_W:0]         fire_sum, fuel_sum;
  logic [FCT_W+4:0]       t_mul;
  logic [FCT_W-2:0]       t_val;
  logic [VAL_W-1:0]       t_sat;
  cell_t                  upd;

  rfgs_div #(.NW(NUM_W), .DVW(DEN_W)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rem_nz)
  );

  rfgs_isqrt #(.VW(VW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  rfgs_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Volume mapping and reject test
  always_comb begin
    exx    = (extent_x == '0) ? POS_W'(1) : extent_x;
    exz    = (extent_z == '0) ? POS_W'(1) : extent_z;
    dxw    = $signed({posx[POS_W-1], posx}) - $signed({center_x[POS_W-1], center_x});
    dzw    = $signed({posz[POS_W-1], posz}) - $signed({center_z[POS_W-1], center_z});
    d2x    = $signed({dxw[24], dxw, 1'b0});
    d2z    = $signed({dzw[24], dzw, 1'b0});
    exsx   = $signed({3'b000, exx});
    exsz   = $signed({3'b000, exz});
    reject = (d2x < -exsx) || (d2x > exsx) || (d2z < -exsz) || (d2z > exsz);
    nxs    = d2x + exsx;
    nzs    = d2z + exsz;
  end

  // Bounding square of the brush
  always_comb begin
    rc  = (rrad > RW'(RCMAX)) ? RCMAX : rrad[RCW-1:0];
    lox = $signed({3'b000, cx}) - $signed({2'b00, rc});
    hix = $signed({3'b000, cx}) + $signed({2'b00, rc});
    loy = $signed({3'b000, cy}) - $signed({2'b00, rc});
    hiy = $signed({3'b000, cy}) + $signed({2'b00, rc});
  end

  // Cell distance and falloff update
  always_comb begin
    dxs      = $signed({{(DW + 1 - CW){1'b0}}, px}) - $signed({1'b0, cx});
    dys      = $signed({{(DW + 1 - CW){1'b0}}, py}) - $signed({1'b0, cy});
    adx      = dxs[DW] ? DW'(-dxs) : dxs[DW-1:0];
    ady      = dys[DW] ? DW'(-dys) : dys[DW-1:0];
    in_circ  = ({1'b0, s} <= rc2);
    last     = (px == xhi) && (py == yhi);
    amt8     = {amt, 3'b000};
    cnt_inc  = (cnt == CHG_MAX) ? cnt : cnt + 1'b1;
    fire_sum = (FCT_W + 1)'(mem_rdata.fire) + (FCT_W + 1)'(fct);
    fuel_sum = (FCT_W + 1)'(mem_rdata.fuel) + (FCT_W + 1)'(fct);
    t_mul    = (FCT_W + 5)'(fct) * (FCT_W + 5)'(25);
    t_val    = t_mul[FCT_W+4:6];
    t_sat    = (t_val > (FCT_W - 1)'(TEMP_MAX)) ? TEMP_MAX : t_val[VAL_W-1:0];
    upd      = mem_rdata;
    if (func_r == FUNC_IGNITE) begin
      upd.fire = (fire_sum > (FCT_W + 1)'(Q15_ONE)) ? Q15_ONE : fire_sum[VAL_W-1:0];
      if (t_sat > mem_rdata.temp) begin
        upd.temp = t_sat;
      end
    end else begin
      upd.fuel = (fuel_sum > (FCT_W + 1)'(Q15_ONE)) ? Q15_ONE : fuel_sum[VAL_W-1:0];
    end
  end

  // Memory addressing
  always_comb begin
    cell_addr = AW'(py) * AW'(GRID_SIZE) + AW'(px);
    rd_addr   = AW'(cyr) * AW'(GRID_SIZE) + AW'(cxr);
    rd_in     = (11'(cxr) < 11'(GRID_SIZE)) && (11'(cyr) < 11'(GRID_SIZE));
    mem_re    = ((state == ST_RD) && rd_in) || ((state == ST_CIRC) && in_circ);
    mem_raddr = (state == ST_RD) ? rd_addr : cell_addr;
    mem_we    = (state == ST_CLR) || (state == ST_WR);
    mem_waddr = (state == ST_CLR) ? clr_addr : cell_addr;
    if (state == ST_CLR) begin
      mem_wdata = '{temp: '0, fire: '0, fuel: clr_fuel};
    end else begin
      mem_wdata = upd;
    end
  end

  assign req_stall = (state != ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_z <= '0;
      extent_x <= EXT_RST;
      extent_z <= EXT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Z: center_z <= cfg_data;
        CFG_EXTENT_X: extent_x <= cfg_data;
        CFG_EXTENT_Z: extent_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      clr_fuel  <= Q15_ONE;
      clr_req   <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            func_r <= func;
            posx   <= pos_x;
            posz   <= pos_z;
            rad    <= radius;
            amt    <= amount;
            cxr    <= cell_x;
            cyr    <= cell_y;
            state  <= ST_CHK;
          end
        end
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= clr_req ? ST_DONE : ST_IDLE;
          end
        end
        ST_CHK: begin
          res_status <= 1'b0;
          res_count  <= '0;
          res_cell   <= '0;
          case (func_r)
            FUNC_RESET: begin
              clr_addr  <= '0;
              clr_fuel  <= (amt8 > FCT_W'(Q15_ONE)) ? Q15_ONE : amt8[VAL_W-1:0];
              clr_req   <= 1'b1;
              res_count <= CLR_CHG;
              state     <= ST_CLR;
            end
            FUNC_READ: begin
              state <= ST_RD;
            end
            default: begin
              if (reject) begin
                res_status <= 1'b1;
                state      <= ST_DONE;
              end else begin
                div_num   <= NUM_W'(nxs[24:0]) * NUM_W'(GRID_SIZE);
                div_den   <= DEN_W'({exx, 1'b0});
                div_start <= 1'b1;
                state     <= ST_DIVX;
              end
            end
          endcase
        end
        ST_DIVX: begin
          if (div_done) begin
            cx        <= div_quo[DW-1:0];
            div_num   <= NUM_W'(nzs[24:0]) * NUM_W'(GRID_SIZE);
            div_den   <= DEN_W'({exz, 1'b0});
            div_start <= 1'b1;
            state     <= ST_DIVZ;
          end
        end
        ST_DIVZ: begin
          if (div_done) begin
            cy        <= div_quo[DW-1:0];
            div_num   <= NUM_W'(rad) * NUM_W'(GRID_SIZE);
            div_den   <= DEN_W'(exx);
            div_start <= 1'b1;
            state     <= ST_DIVR;
          end
        end
        ST_DIVR: begin
          if (div_done) begin
            // radius in cells, at least one
            rrad  <= (div_quo[RW-1:0] == '0) ? RW'(1) : div_quo[RW-1:0];
            state <= ST_SETP;
          end
        end
        ST_SETP: begin
          rc2   <= RC2W'(rc) * RC2W'(rc);
          xlo   <= lox[BW-1] ? '0 : lox[CW-1:0];
          ylo   <= loy[BW-1] ? '0 : loy[CW-1:0];
          xhi   <= (hix > BW'(GRID_SIZE - 1)) ? CW'(GRID_SIZE - 1) : hix[CW-1:0];
          yhi   <= (hiy > BW'(GRID_SIZE - 1)) ? CW'(GRID_SIZE - 1) : hiy[CW-1:0];
          px    <= lox[BW-1] ? '0 : lox[CW-1:0];
          py    <= loy[BW-1] ? '0 : loy[CW-1:0];
          cnt   <= '0;
          state <= ST_CELL;
        end
        ST_CELL: begin
          s     <= SW'(adx) * SW'(adx) + SW'(ady) * SW'(ady);
          state <= ST_CIRC;
        end
        ST_CIRC: begin
          if (in_circ) begin
            sq_val   <= VW'({s, 16'h0000});
            sq_start <= 1'b1;
            state    <= ST_SQRT;
          end else begin
            // outside the circle: move on without touching the store
            if (px == xhi) begin
              px <= xlo;
              py <= py + 1'b1;
            end else begin
              px <= px + 1'b1;
            end
            if (last) begin
              res_count <= cnt;
              state     <= ST_DONE;
            end else begin
              state <= ST_CELL;
            end
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            // factor = A - ceil(A*q / 256r)
            div_num   <= NUM_W'(amt8) * NUM_W'(sq_root);
            div_den   <= DEN_W'({rrad, 8'h00});
            div_start <= 1'b1;
            state     <= ST_DIVF;
          end
        end
        ST_DIVF: begin
          if (div_done) begin
            fct   <= amt8 - div_quo[FCT_W-1:0] - FCT_W'(div_rem_nz);
            state <= ST_WR;
          end
        end
        ST_WR: begin
          cnt <= cnt_inc;
          if (px == xhi) begin
            px <= xlo;
            py <= py + 1'b1;
          end else begin
            px <= px + 1'b1;
          end
          if (last) begin
            res_count <= cnt_inc;
            state     <= ST_DONE;
          end else begin
            state <= ST_CELL;
          end
        end
        ST_RD: begin
          state <= rd_in ? ST_RDW : ST_DONE;
        end
        ST_RDW: begin
          res_cell <= mem_rdata;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            status        <= res_status;
            cells_changed <= res_count;
            fuel_out      <= res_cell.fuel;
            fire_out      <= res_cell.fire;
            temp_out      <= res_cell.temp;
            clr_req       <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `RFGS_ASSERT_IMP(a_rej_nochg, rsp_valid && status, cells_changed == '0, "rejected stamp reports written cells")
  `RFGS_ASSERT_IMP(a_write_noread, rsp_valid && (cells_changed != '0), (fuel_out == '0) && (fire_out == '0) && (temp_out == '0), "write request returns cell data")
  `RFGS_ASSERT_NXT(a_acc_busy, req_valid && !req_stall, state != ST_IDLE, "accepted word left sequencer idle")

endmodule

`default_nettype wire
